// ----- hdl/rbsi_pkg.sv -----
package rbsi_pkg;

   // Coordinate format, fixed by the payload
   localparam int CoordWidth   = 32;
   localparam int DefFracBits  = 16;
   localparam int DistWidth    = 31;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 32;
   localparam int FaceWidth    = 3;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CsrLowX  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrLowY  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrLowZ  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrHighX = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrHighY = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrHighZ = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CsrMinDist = 3'd6;

   // Face codes of the hit normal
   localparam logic [FaceWidth-1:0] FaceNegX = 3'd0;
   localparam logic [FaceWidth-1:0] FaceNegY = 3'd1;
   localparam logic [FaceWidth-1:0] FaceNegZ = 3'd2;
   localparam logic [FaceWidth-1:0] FacePosX = 3'd3;
   localparam logic [FaceWidth-1:0] FacePosY = 3'd4;
   localparam logic [FaceWidth-1:0] FacePosZ = 3'd5;

   localparam logic [CoordWidth-1:0] ResetLow   = 32'd0;
   localparam logic [CoordWidth-1:0] ResetHigh  = 32'd65536;
   localparam logic [DistWidth-1:0]  ResetMinDist = 31'd66;

   typedef struct packed {
      logic [CoordWidth-1:0] origin_x;
      logic [CoordWidth-1:0] origin_y;
      logic [CoordWidth-1:0] origin_z;
      logic [CoordWidth-1:0] dir_x;
      logic [CoordWidth-1:0] dir_y;
      logic [CoordWidth-1:0] dir_z;
   } rbsi_req_type;

   typedef struct packed {
      logic                 found;
      logic [DistWidth-1:0] distance;
      logic [FaceWidth-1:0] face_index;
      logic                 from_inside;
   } rbsi_rsp_type;

   // Side information that travels with one slab division
   typedef struct packed {
      logic neg;     // quotient sign
      logic zero;    // direction component is zero
      logic nzero;   // corner equals origin
      logic nneg;    // corner lies below origin
   } rbsi_tag_type;

endpackage

// ----- hdl/rbsi_slab_div.sv -----
module rbsi_slab_div #(
   parameter int FRAC_BITS = rbsi_pkg::DefFracBits,
   parameter bit ENTRY     = 1'b1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [rbsi_pkg::CoordWidth-1:0] corner,
   input  logic signed [rbsi_pkg::CoordWidth-1:0] origin,
   input  logic signed [rbsi_pkg::CoordWidth-1:0] dir,
   output logic                                 out_valid,
   output logic signed [rbsi_pkg::CoordWidth-1:0] out_time
);
   import rbsi_pkg::*;

   localparam int NumWidth = CoordWidth + 1 + FRAC_BITS;
   localparam int QWidth   = CoordWidth - 1;
   localparam logic [QWidth-1:0] TMax = '1;

   logic                  valid_ff [0:NumWidth];
   logic [NumWidth-1:0]   num_ff   [0:NumWidth];
   logic [CoordWidth-1:0] div_ff   [0:NumWidth];
   logic [CoordWidth-1:0] rem_ff   [0:NumWidth];
   logic [QWidth-1:0]     quo_ff   [0:NumWidth];
   logic                  sat_ff   [0:NumWidth];
   rbsi_tag_type          tag_ff   [0:NumWidth];

   logic signed [CoordWidth:0] diff;
   logic [CoordWidth:0]        nmag;
   logic [CoordWidth-1:0]      dmag;
   rbsi_tag_type               tag_in;

   // Split numerator and divisor into sign and magnitude
   always_comb begin
      diff = {corner[CoordWidth-1], corner} - {origin[CoordWidth-1], origin};
      nmag = diff[CoordWidth] ? (CoordWidth+1)'(-diff) : diff;
      dmag = dir[CoordWidth-1] ? CoordWidth'(-dir) : dir;
      tag_in.nneg  = diff[CoordWidth];
      tag_in.neg   = diff[CoordWidth] ^ dir[CoordWidth-1];
      tag_in.zero  = (dir == '0);
      tag_in.nzero = (diff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      num_ff[0] <= {nmag, {FRAC_BITS{1'b0}}};
      div_ff[0] <= dmag;
      rem_ff[0] <= '0;
      quo_ff[0] <= '0;
      sat_ff[0] <= 1'b0;
      tag_ff[0] <= tag_in;
   end

   // One quotient bit per stage, restoring division
   for (genvar k = 0; k < NumWidth; k++) begin : g_stage
      logic [CoordWidth:0] rem2;
      logic                ge;
      logic [CoordWidth:0] sub;

      always_comb begin
         rem2 = {rem_ff[k], num_ff[k][NumWidth-1]};
         sub  = rem2 - {1'b0, div_ff[k]};
         ge   = (rem2 >= {1'b0, div_ff[k]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         num_ff[k+1] <= {num_ff[k][NumWidth-2:0], 1'b0};
         div_ff[k+1] <= div_ff[k];
         rem_ff[k+1] <= ge ? sub[CoordWidth-1:0] : rem2[CoordWidth-1:0];
         quo_ff[k+1] <= {quo_ff[k][QWidth-2:0], ge};
         // a bit shifted out of the top means the quotient passed TMax
         sat_ff[k+1] <= sat_ff[k] | quo_ff[k][QWidth-1];
         tag_ff[k+1] <= tag_ff[k];
      end
   end

   logic [CoordWidth-1:0] mag;
   logic [CoordWidth-1:0] pos_max;
   logic [CoordWidth-1:0] time_in;
   rbsi_tag_type          tag_end;

   // Saturate, apply sign, handle zero direction
   always_comb begin
      tag_end = tag_ff[NumWidth];
      pos_max = {1'b0, TMax};
      mag     = sat_ff[NumWidth] ? pos_max : {1'b0, quo_ff[NumWidth]};
      if (tag_end.zero) begin
         if (tag_end.nzero) begin
            time_in = ENTRY ? CoordWidth'(-pos_max) : pos_max;
         end else begin
            time_in = tag_end.nneg ? CoordWidth'(-pos_max) : pos_max;
         end
      end else begin
         time_in = tag_end.neg ? CoordWidth'(-mag) : mag;
      end
   end

   logic                  out_valid_ff;
   logic [CoordWidth-1:0] out_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[NumWidth];
      end
      out_time_ff <= time_in;
   end

   assign out_valid = out_valid_ff;
   assign out_time  = out_time_ff;

endmodule

// ----- hdl/rbsi_select.sv -----
module rbsi_select (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [2:0][rbsi_pkg::CoordWidth-1:0]   t_entry,
   input  logic [2:0][rbsi_pkg::CoordWidth-1:0]   t_exit,
   input  logic [2:0]                             pos,
   input  logic [rbsi_pkg::DistWidth-1:0]         min_distance,
   output logic                                   out_valid,
   output rbsi_pkg::rbsi_rsp_type                 out_rsp
);
   import rbsi_pkg::*;

   localparam logic [CoordWidth-1:0] DistMax = CoordWidth'({DistWidth{1'b1}});

   logic signed [CoordWidth-1:0] tl_in, ts_in;
   logic [FaceWidth-1:0]         inf_in, outf_in;
   logic signed [CoordWidth-1:0] tl_ff, ts_ff;
   logic [FaceWidth-1:0]         inf_ff, outf_ff;
   logic                         valid_a_ff;

   // Latest entry and earliest exit with their faces
   always_comb begin
      if ($signed(t_entry[0]) > $signed(t_entry[1])) begin
         tl_in  = t_entry[0];
         inf_in = pos[0] ? FaceNegX : FacePosX;
      end else begin
         tl_in  = t_entry[1];
         inf_in = pos[1] ? FaceNegY : FacePosY;
      end
      if ($signed(t_entry[2]) > tl_in) begin
         tl_in  = t_entry[2];
         inf_in = pos[2] ? FaceNegZ : FacePosZ;
      end
      if ($signed(t_exit[0]) < $signed(t_exit[1])) begin
         ts_in   = t_exit[0];
         outf_in = pos[0] ? FacePosX : FaceNegX;
      end else begin
         ts_in   = t_exit[1];
         outf_in = pos[1] ? FacePosY : FaceNegY;
      end
      if ($signed(t_exit[2]) < ts_in) begin
         ts_in   = t_exit[2];
         outf_in = pos[2] ? FacePosZ : FaceNegZ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      tl_ff   <= tl_in;
      ts_ff   <= ts_in;
      inf_ff  <= inf_in;
      outf_ff <= outf_in;
   end

   logic signed [CoordWidth:0] eps;
   logic signed [CoordWidth:0] tl_x, ts_x;
   logic [CoordWidth-1:0]      t_sel;
   rbsi_rsp_type               rsp_in;

   // Decide hit, pick reported time, clamp distance
   always_comb begin
      eps  = $signed((CoordWidth+1)'(min_distance));
      tl_x = {tl_ff[CoordWidth-1], tl_ff};
      ts_x = {ts_ff[CoordWidth-1], ts_ff};
      rsp_in = '0;
      t_sel  = '0;
      if ((tl_ff < ts_ff) && (ts_x > eps)) begin
         if (tl_x > eps) begin
            t_sel              = tl_ff;
            rsp_in.face_index  = inf_ff;
            rsp_in.from_inside = 1'b0;
         end else begin
            t_sel              = ts_ff;
            rsp_in.face_index  = outf_ff;
            rsp_in.from_inside = 1'b1;
         end
         rsp_in.found    = 1'b1;
         rsp_in.distance = (t_sel > DistMax) ? DistMax[DistWidth-1:0]
                                             : t_sel[DistWidth-1:0];
      end
   end

   logic         valid_b_ff;
   rbsi_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_b_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- hdl/ray_box_slab_intersect_core.sv -----
// Ray against axis-aligned box, slab method, Q16.16 fixed point.
// Requests: a ray (origin, direction) on req_data is taken at each rising
// edge where start is high; busy stays low, so a request can enter every
// cycle. Each request gives exactly one response on rsp_data, marked by a
// one-cycle rsp_valid strobe, in request order.
// Stages in order: one prep stage, one restoring-division stage per
// quotient bit in each of the six slab dividers, one sign/saturate stage,
// then two compare stages. Throughput is one ray per cycle; the division
// pipeline sets the depth. Box corners and the minimum hit distance are
// written through the csr_ port (index 0..6, other indexes ignored); the
// user must write them only while no request is in flight; the block does
// not enforce it. Reset empties the pipeline, restores the unit box [0,1]^3
// and minimum distance 66. The receiver cannot stall, so nothing backs up.
module ray_box_slab_intersect_core #(
   parameter int FRAC_BITS = rbsi_pkg::DefFracBits
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rbsi_pkg::rbsi_req_type             req_data,
   output logic                               rsp_valid,
   output rbsi_pkg::rbsi_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [rbsi_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [rbsi_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import rbsi_pkg::*;

   localparam int DivLatency = CoordWidth + 1 + FRAC_BITS + 2;

   logic [2:0][CoordWidth-1:0] low_ff, high_ff;
   logic [DistWidth-1:0]       min_dist_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= {3{ResetLow}};
         high_ff     <= {3{ResetHigh}};
         min_dist_ff <= ResetMinDist;
      end else if (csr_we) begin
         case (csr_index)
            CsrLowX:    low_ff[0]   <= csr_wdata[CoordWidth-1:0];
            CsrLowY:    low_ff[1]   <= csr_wdata[CoordWidth-1:0];
            CsrLowZ:    low_ff[2]   <= csr_wdata[CoordWidth-1:0];
            CsrHighX:   high_ff[0]  <= csr_wdata[CoordWidth-1:0];
            CsrHighY:   high_ff[1]  <= csr_wdata[CoordWidth-1:0];
            CsrHighZ:   high_ff[2]  <= csr_wdata[CoordWidth-1:0];
            CsrMinDist: min_dist_ff <= csr_wdata[DistWidth-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic                       accept;
   logic [2:0][CoordWidth-1:0] origin, dir;
   logic [2:0]                 pos_in;

   always_comb begin
      accept    = start & ~busy;
      origin[0] = req_data.origin_x;
      origin[1] = req_data.origin_y;
      origin[2] = req_data.origin_z;
      dir[0]    = req_data.dir_x;
      dir[1]    = req_data.dir_y;
      dir[2]    = req_data.dir_z;
      for (int k = 0; k < 3; k++) begin
         pos_in[k] = ~dir[k][CoordWidth-1];
      end
   end

   logic [2:0][CoordWidth-1:0] t_entry, t_exit;
   logic [2:0]                 v_entry, v_exit;

   // Two slab dividers per axis; corners swap for negative direction
   for (genvar k = 0; k < 3; k++) begin : g_axis
      rbsi_slab_div #(.FRAC_BITS(FRAC_BITS), .ENTRY(1'b1)) u_entry (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (accept),
         .corner    (pos_in[k] ? low_ff[k] : high_ff[k]),
         .origin    (origin[k]),
         .dir       (dir[k]),
         .out_valid (v_entry[k]),
         .out_time  (t_entry[k])
      );
      rbsi_slab_div #(.FRAC_BITS(FRAC_BITS), .ENTRY(1'b0)) u_exit (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (accept),
         .corner    (pos_in[k] ? high_ff[k] : low_ff[k]),
         .origin    (origin[k]),
         .dir       (dir[k]),
         .out_valid (v_exit[k]),
         .out_time  (t_exit[k])
      );
   end

   // Carry direction signs alongside the dividers
   logic [2:0] pos_ff [0:DivLatency-1];

   always_ff @(posedge clock) begin
      pos_ff[0] <= pos_in;
      for (int s = 1; s < DivLatency; s++) begin
         pos_ff[s] <= pos_ff[s-1];
      end
   end

   logic div_valid;
   assign div_valid = v_entry[0] & v_exit[0] & v_entry[1] & v_exit[1]
                      & v_entry[2] & v_exit[2];

   rbsi_select u_select (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (div_valid),
      .t_entry      (t_entry),
      .t_exit       (t_exit),
      .pos          (pos_ff[DivLatency-1]),
      .min_distance (min_dist_ff),
      .out_valid    (rsp_valid),
      .out_rsp      (rsp_data)
   );

endmodule

// ----- tb/ray_box_slab_intersect_core_tb.sv -----
module ray_box_slab_intersect_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbsi_pkg::*;

   localparam longint TMax      = 64'h7FFF_FFFF;
   localparam int     PipeDepth = 53;
   localparam int     CycleLimit = 400000;
   localparam int     One       = 65536;

   typedef struct {
      rbsi_req_type ray;
      bit           typed;
      rbsi_rsp_type hit;
   } ray_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   rbsi_req_type            req_data = '0;
   logic                    rsp_valid;
   rbsi_rsp_type            rsp_data;
   logic                    csr_we = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // box copy held by the predictor
   longint         box_lo[3];
   longint         box_hi[3];
   logic [30:0]    box_min_dist;

   rbsi_rsp_type   pending_hits[$];
   int             mismatches = 0;
   int             typed_errors = 0;
   int             cycles = 0;
   int             rays_sent = 0;
   int             hits_seen = 0;
   int             misses_seen = 0;
   int             inside_seen = 0;

   ray_box_slab_intersect_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // crossing time of one plane, truncated quotient saturated to TMax
   function automatic longint plane_time(longint c, longint o, longint d, bit entry);
      longint unsigned n, m, q, r, q2, r2;
      bit nneg, dneg;
      if (c >= o) begin
         n = c - o;
         nneg = 1'b0;
      end else begin
         n = o - c;
         nneg = 1'b1;
      end
      if (d == 0) begin
         if (n == 0) return entry ? -TMax : TMax;
         return nneg ? -TMax : TMax;
      end
      dneg = d < 0;
      m = dneg ? -d : d;
      q = n / m;
      r = n % m;
      if (q > TMax) begin
         q = TMax;
      end else begin
         for (int i = 0; i < DefFracBits; i++) begin
            q2 = q << 1;
            r2 = r << 1;
            if (r2 >= m) begin
               r2 -= m;
               q2 |= 1;
            end
            if (q2 > TMax) begin
               q = TMax;
               break;
            end
            q = q2;
            r = r2;
         end
      end
      return (nneg != dneg) ? -longint'(q) : longint'(q);
   endfunction

   // expected hit record of one ray against the current box
   function automatic rbsi_rsp_type box_hit(rbsi_req_type ray);
      longint t_in[3], t_out[3], o, d, t_late, t_early;
      bit pos[3];
      logic [31:0] org[3], dir[3];
      logic [FaceWidth-1:0] f_in, f_out;
      rbsi_rsp_type res;
      org = '{ray.origin_x, ray.origin_y, ray.origin_z};
      dir = '{ray.dir_x, ray.dir_y, ray.dir_z};
      for (int k = 0; k < 3; k++) begin
         o = longint'($signed(org[k]));
         d = longint'($signed(dir[k]));
         pos[k] = d >= 0;
         t_in[k]  = plane_time(pos[k] ? box_lo[k] : box_hi[k], o, d, 1'b1);
         t_out[k] = plane_time(pos[k] ? box_hi[k] : box_lo[k], o, d, 1'b0);
      end
      if (t_in[0] > t_in[1]) begin
         t_late = t_in[0];
         f_in = pos[0] ? FaceNegX : FacePosX;
      end else begin
         t_late = t_in[1];
         f_in = pos[1] ? FaceNegY : FacePosY;
      end
      if (t_in[2] > t_late) begin
         t_late = t_in[2];
         f_in = pos[2] ? FaceNegZ : FacePosZ;
      end
      if (t_out[0] < t_out[1]) begin
         t_early = t_out[0];
         f_out = pos[0] ? FacePosX : FaceNegX;
      end else begin
         t_early = t_out[1];
         f_out = pos[1] ? FacePosY : FaceNegY;
      end
      if (t_out[2] < t_early) begin
         t_early = t_out[2];
         f_out = pos[2] ? FacePosZ : FaceNegZ;
      end
      res = '0;
      if (t_late < t_early && t_early > longint'(box_min_dist)) begin
         res.found = 1'b1;
         if (t_late > longint'(box_min_dist)) begin
            res.distance = t_late[30:0];
            res.face_index = f_in;
         end else begin
            res.distance = t_early[30:0];
            res.face_index = f_out;
            res.from_inside = 1'b1;
         end
      end
      return res;
   endfunction

   // record accepted requests, check each strobed result against the oldest one
   always @(posedge clock) begin
      rbsi_rsp_type want;
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            pending_hits.push_back(box_hit(req_data));
            rays_sent <= rays_sent + 1;
         end
         if (rsp_valid) begin
            if (pending_hits.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = pending_hits.pop_front();
               if (rsp_data.found !== want.found || rsp_data.distance !== want.distance ||
                   rsp_data.face_index !== want.face_index ||
                   rsp_data.from_inside !== want.from_inside) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10) $display("result mismatch: expected %p got %p",
                                                want, rsp_data);
               end
               if (want.found) hits_seen <= hits_seen + 1;
               else misses_seen <= misses_seen + 1;
               if (want.from_inside) inside_seen <= inside_seen + 1;
            end
         end
      end
   end

   // give up on a hung block
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic write_reg(logic [CsrIdxWidth-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx <= CsrLowZ) box_lo[idx] = longint'($signed(value));
      else if (idx <= CsrHighZ) box_hi[idx - CsrHighX] = longint'($signed(value));
      else if (idx == CsrMinDist) box_min_dist = value[30:0];
   endtask

   task automatic set_box(int lx, int ly, int lz, int hx, int hy, int hz, int md);
      write_reg(CsrLowX, lx);
      write_reg(CsrLowY, ly);
      write_reg(CsrLowZ, lz);
      write_reg(CsrHighX, hx);
      write_reg(CsrHighY, hy);
      write_reg(CsrHighZ, hz);
      write_reg(CsrMinDist, md);
   endtask

   // hold start high until the request is taken
   task automatic send_ray(rbsi_req_type ray);
      @(negedge clock);
      start = 1'b1;
      req_data = ray;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (PipeDepth + 8) @(posedge clock);
   endtask

   function automatic int rand_coord(int span);
      return $signed($urandom_range(0, 2 * span * One)) - span * One;
   endfunction

   // mostly rays aimed at a point of the box from outside or inside, some noise
   task automatic random_rays(int count);
      rbsi_req_type ray;
      int burst, gap, tx, ty, tz, sh;
      int left;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && left > 0; b++) begin
            if ($urandom_range(0, 4) == 0) begin
               ray = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
               if ($urandom_range(0, 3) == 0) ray.dir_y = '0;
            end else begin
               tx = int'(box_lo[0] + (box_hi[0] - box_lo[0]) * $urandom_range(0, 100) / 100);
               ty = int'(box_lo[1] + (box_hi[1] - box_lo[1]) * $urandom_range(0, 100) / 100);
               tz = int'(box_lo[2] + (box_hi[2] - box_lo[2]) * $urandom_range(0, 100) / 100);
               ray.origin_x = rand_coord(20);
               ray.origin_y = rand_coord(20);
               ray.origin_z = rand_coord(20);
               sh = $urandom_range(0, 6);
               ray.dir_x = (tx - int'($signed(ray.origin_x))) >>> sh;
               ray.dir_y = (ty - int'($signed(ray.origin_y))) >>> sh;
               ray.dir_z = (tz - int'($signed(ray.origin_z))) >>> sh;
               if ($urandom_range(0, 7) == 0) ray.dir_z = '0;
               if ($urandom_range(0, 7) == 0) ray.dir_x = -ray.dir_x;
            end
            send_ray(ray);
            left--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   ray_row_type rows[$];

   function automatic rbsi_req_type mk(int ox, int oy, int oz, int dx, int dy, int dz);
      return {ox, oy, oz, dx, dy, dz};
   endfunction

   initial begin
      ray_row_type row;
      int hx, hy, hz;
      for (int k = 0; k < 3; k++) begin
         box_lo[k] = 0;
         box_hi[k] = One;
      end
      box_min_dist = ResetMinDist;

      // hit from -x, miss, origin inside, then extremes, ties and zero directions
      rows.push_back('{mk(-One, One/2, One/2, One, 0, 0), 1, '{1'b1, 31'd65536, FaceNegX, 1'b0}});
      rows.push_back('{mk(2*One, 2*One, 2*One, One, 0, 0), 1, '0});
      rows.push_back('{mk(One/2, One/2, One/2, One, 0, 0), 1, '{1'b1, 31'd32768, FacePosX, 1'b1}});
      rows.push_back('{mk(0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(One/2, One/2, One/2, 0, 0, 0), 0, '0});
      rows.push_back('{mk(-One, -One, -One, One, One, One), 0, '0});
      rows.push_back('{mk(2*One, 2*One, 2*One, -One, -One, -One), 0, '0});
      rows.push_back('{mk(-One, -One, One/2, One, One, 0), 0, '0});
      rows.push_back('{mk(One/2, -One, -One, 0, One, One), 0, '0});
      rows.push_back('{mk(-One, One/2, -2*One, One, 0, 2*One), 0, '0});
      rows.push_back('{mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, '0});
      rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, '0});
      rows.push_back('{mk(32'h8000_0000, One/2, One/2, 1, 0, 0), 0, '0});
      rows.push_back('{mk(-One, One/2, One/2, 1, 0, 0), 0, '0});
      rows.push_back('{mk(0, 0, 0, 32'hFFFF_FFFF, 1, 32'h8000_0000), 0, '0});
      rows.push_back('{mk(One, One, One, -One, -One, -One), 0, '0});
      rows.push_back('{mk(One/2, One/2, 66, 0, 0, One), 0, '0});
      rows.push_back('{mk(One/2, One/2, 0, 0, 0, -One), 0, '0});
      rows.push_back('{mk(-One, One/2, One/2, -One, 0, 0), 0, '0});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows at the reset box
      foreach (rows[i]) begin
         row = rows[i];
         send_ray(row.ray);
         if (row.typed && box_hit(row.ray) != row.hit) begin
            typed_errors++;
            $display("row %0d: expected %p, predictor gives %p", i, row.hit,
                     box_hit(row.ray));
         end
      end
      random_rays(250);
      drain();

      // random box, every register and an unused index
      hx = $urandom_range(1, 8) * One;
      hy = $urandom_range(1, 8) * One + $urandom_range(0, One);
      hz = $urandom_range(1, 8) * One;
      set_box(-$urandom_range(0, 4*One), -$urandom_range(0, 8*One), -3*One, hx, hy, hz,
              $urandom_range(0, One));
      write_reg(3'd7, $urandom);
      random_rays(280);
      drain();

      // widest box and zero minimum distance
      set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      foreach (rows[i]) send_ray(rows[i].ray);
      random_rays(260);
      drain();

      // small box far out, then the largest minimum distance
      set_box(3*One, -5*One, One, 5*One, -4*One, 9*One, 4*One);
      random_rays(200);
      drain();
      write_reg(CsrMinDist, 32'h7FFF_FFFF);
      random_rays(60);
      drain();

      $display("%0d rays over five box settings: %0d hits (%0d from inside), %0d misses",
               rays_sent, hits_seen, inside_seen, misses_seen);
      if (mismatches == 0 && typed_errors == 0 && pending_hits.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d typed rows off", mismatches, typed_errors);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
